/* hdl/bile_pkg.sv */
// ----------------------------------------------------------------------------
// bile_pkg
// Shared types and codes for the bounded integer list engine.
// ----------------------------------------------------------------------------
package bile_pkg;

    // operation codes carried in the mode field
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_INSERT     = 3'd3;
    localparam logic [2:0] MODE_SORT       = 3'd4;
    localparam logic [2:0] MODE_DEDUP      = 3'd5;
    localparam logic [2:0] MODE_CLEAR      = 3'd6;
    localparam logic [2:0] MODE_QUERY      = 3'd7;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // word layout
    localparam int IN_W  = 40;
    localparam int OUT_W = 80;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SHR_RD,
        ST_SHR_WR,
        ST_PUT,
        ST_SHL_RD,
        ST_SHL_WR,
        ST_INS_RD0,
        ST_INS_CK0,
        ST_INS_RDL,
        ST_INS_CKL,
        ST_INS_RDP,
        ST_INS_CKP,
        ST_SRT_RDI,
        ST_SRT_GETI,
        ST_SRT_RDJ,
        ST_SRT_CMPJ,
        ST_SRT_WRI,
        ST_SRT_WRM,
        ST_DDP_RDR,
        ST_DDP_GETR,
        ST_DDP_RDK,
        ST_DDP_CMPK,
        ST_DDP_WRW,
        ST_FIN,
        ST_FIN_RDF,
        ST_FIN_RDB,
        ST_FIN_GETB,
        ST_OUT
    } state_t;

endpackage

/* hdl/bounded_integer_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_integer_list_engine
// Each operation walks the element memory through its registered read port:
// push front and pop shift every held entry by one, ordered insert checks
// front and back and then scans before shifting, sort is a selection sort and
// dedup compares each entry with those kept so far.
// One word in flight at a time; a new word is taken while a result waits.
// Reset (aresetn low, synchronous) empties the list and drops any result.
// ----------------------------------------------------------------------------
module bounded_integer_list_engine
    import bile_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mode [2:0], item_value [34:3], zero [39:35]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status [1:0], front_value [33:2], back_value [65:34],
    // entry_count [72:66], list_empty [73], zero [79:74]
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [CW-1:0] C_ZERO  = CW'(0);
    localparam logic [CW-1:0] C_DEPTH = CW'(DEPTH);

    // element memory
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;
    logic [CW-1:0]      rd_addr;
    logic [CW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               mem_we;

    state_t state_reg, state_next;
    logic [2:0]         mode_reg, mode_next;
    logic signed [31:0] val_reg, val_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      m_reg, m_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      w_reg, w_next;
    logic signed [31:0] ival_reg, ival_next;
    logic signed [31:0] mval_reg, mval_next;
    logic signed [31:0] front_reg, front_next;
    logic signed [31:0] back_reg, back_next;
    logic               ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]   odata_reg, odata_next;

    logic [CW-1:0]      i_inc;
    logic [CW+6:0]      cnt_wide;
    logic               full;

    assign i_inc    = i_reg + C_ONE;
    assign full     = (cnt_reg == C_DEPTH);
    assign cnt_wide = {7'd0, cnt_reg};

    // memory port, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= C_ZERO;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        p_reg      <= p_next;
        w_reg      <= w_next;
        ival_reg   <= ival_next;
        mval_reg   <= mval_next;
        front_reg  <= front_next;
        back_reg   <= back_next;
        odata_reg  <= odata_next;
    end

    // sequencer: next state and working registers
    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        p_next      = p_reg;
        w_next      = w_reg;
        ival_next   = ival_reg;
        mval_next   = mval_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = s_tdata[2:0];
                    val_next    = s_tdata[34:3];
                    status_next = STATUS_DONE;
                    state_next  = ST_FIN;
                    unique case (s_tdata[2:0])
                        MODE_PUSH_FRONT: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                p_next     = C_ZERO;
                                i_next     = cnt_reg;
                                state_next = ST_SHR_RD;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                p_next     = cnt_reg;
                                state_next = ST_PUT;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (cnt_reg == C_ZERO) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                i_next     = C_ZERO;
                                state_next = ST_SHL_RD;
                            end
                        end
                        MODE_INSERT: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else if (cnt_reg == C_ZERO) begin
                                p_next     = C_ZERO;
                                i_next     = cnt_reg;
                                state_next = ST_SHR_RD;
                            end else begin
                                state_next = ST_INS_RD0;
                            end
                        end
                        MODE_SORT: begin
                            i_next     = C_ZERO;
                            state_next = ST_SRT_RDI;
                        end
                        MODE_DEDUP: begin
                            i_next     = C_ZERO;
                            w_next     = C_ZERO;
                            state_next = ST_DDP_RDR;
                        end
                        MODE_CLEAR: begin
                            cnt_next = C_ZERO;
                        end
                        MODE_QUERY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // shift entries p..cnt-1 up by one
            ST_SHR_RD: begin
                state_next = (i_reg > p_reg) ? ST_SHR_WR : ST_PUT;
            end
            ST_SHR_WR: begin
                i_next     = i_reg - C_ONE;
                state_next = ST_SHR_RD;
            end
            ST_PUT: begin
                cnt_next   = cnt_reg + C_ONE;
                state_next = ST_FIN;
            end
            // shift entries down by one over the front
            ST_SHL_RD: begin
                if (i_inc < cnt_reg) begin
                    state_next = ST_SHL_WR;
                end else begin
                    cnt_next   = cnt_reg - C_ONE;
                    state_next = ST_FIN;
                end
            end
            ST_SHL_WR: begin
                i_next     = i_inc;
                state_next = ST_SHL_RD;
            end
            // ordered insert: front, back, then scan
            ST_INS_RD0: begin
                state_next = ST_INS_CK0;
            end
            ST_INS_CK0: begin
                if (val_reg <= rdata_reg) begin
                    p_next     = C_ZERO;
                    i_next     = cnt_reg;
                    state_next = ST_SHR_RD;
                end else begin
                    state_next = ST_INS_RDL;
                end
            end
            ST_INS_RDL: begin
                state_next = ST_INS_CKL;
            end
            ST_INS_CKL: begin
                i_next = cnt_reg;
                if (val_reg >= rdata_reg) begin
                    p_next     = cnt_reg;
                    state_next = ST_SHR_RD;
                end else begin
                    p_next     = C_ONE;
                    state_next = ST_INS_RDP;
                end
            end
            ST_INS_RDP: begin
                state_next = (p_reg < cnt_reg) ? ST_INS_CKP : ST_SHR_RD;
            end
            ST_INS_CKP: begin
                if (rdata_reg < val_reg) begin
                    p_next     = p_reg + C_ONE;
                    state_next = ST_INS_RDP;
                end else begin
                    state_next = ST_SHR_RD;
                end
            end
            // selection sort
            ST_SRT_RDI: begin
                state_next = (i_inc < cnt_reg) ? ST_SRT_GETI : ST_FIN;
            end
            ST_SRT_GETI: begin
                ival_next  = rdata_reg;
                mval_next  = rdata_reg;
                m_next     = i_reg;
                j_next     = i_inc;
                state_next = ST_SRT_RDJ;
            end
            ST_SRT_RDJ: begin
                state_next = (j_reg < cnt_reg) ? ST_SRT_CMPJ : ST_SRT_WRI;
            end
            ST_SRT_CMPJ: begin
                if (rdata_reg < mval_reg) begin
                    mval_next = rdata_reg;
                    m_next    = j_reg;
                end
                j_next     = j_reg + C_ONE;
                state_next = ST_SRT_RDJ;
            end
            ST_SRT_WRI: begin
                state_next = ST_SRT_WRM;
            end
            ST_SRT_WRM: begin
                i_next     = i_inc;
                state_next = ST_SRT_RDI;
            end
            // dedup, first occurrence kept
            ST_DDP_RDR: begin
                if (i_reg < cnt_reg) begin
                    state_next = ST_DDP_GETR;
                end else begin
                    cnt_next   = w_reg;
                    state_next = ST_FIN;
                end
            end
            ST_DDP_GETR: begin
                ival_next  = rdata_reg;
                j_next     = C_ZERO;
                state_next = ST_DDP_RDK;
            end
            ST_DDP_RDK: begin
                state_next = (j_reg < w_reg) ? ST_DDP_CMPK : ST_DDP_WRW;
            end
            ST_DDP_CMPK: begin
                if (rdata_reg == ival_reg) begin
                    i_next     = i_inc;
                    state_next = ST_DDP_RDR;
                end else begin
                    j_next     = j_reg + C_ONE;
                    state_next = ST_DDP_RDK;
                end
            end
            ST_DDP_WRW: begin
                w_next     = w_reg + C_ONE;
                i_next     = i_inc;
                state_next = ST_DDP_RDR;
            end
            // fetch front and back for the result
            ST_FIN: begin
                if (cnt_reg == C_ZERO) begin
                    front_next = 32'sd0;
                    back_next  = 32'sd0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_FIN_RDF;
                end
            end
            ST_FIN_RDF: begin
                state_next = ST_FIN_RDB;
            end
            ST_FIN_RDB: begin
                front_next = rdata_reg;
                state_next = ST_FIN_GETB;
            end
            ST_FIN_GETB: begin
                back_next  = rdata_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = {6'd0, (cnt_reg == C_ZERO), cnt_wide[6:0],
                                   back_reg, front_reg, status_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        rd_addr  = C_ZERO;
        wr_addr  = C_ZERO;
        wr_data  = rdata_reg;
        mem_we   = 1'b0;
        s_tready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_SHR_RD:   rd_addr = i_reg - C_ONE;
            ST_SHR_WR: begin
                mem_we  = 1'b1;
                wr_addr = i_reg;
            end
            ST_PUT: begin
                mem_we  = 1'b1;
                wr_addr = p_reg;
                wr_data = val_reg;
            end
            ST_SHL_RD:   rd_addr = i_inc;
            ST_SHL_WR: begin
                mem_we  = 1'b1;
                wr_addr = i_reg;
            end
            ST_INS_RD0:  rd_addr = C_ZERO;
            ST_INS_RDL:  rd_addr = cnt_reg - C_ONE;
            ST_INS_RDP:  rd_addr = p_reg;
            ST_SRT_RDI:  rd_addr = i_reg;
            ST_SRT_RDJ:  rd_addr = j_reg;
            ST_SRT_WRI: begin
                mem_we  = 1'b1;
                wr_addr = i_reg;
                wr_data = mval_reg;
            end
            ST_SRT_WRM: begin
                mem_we  = 1'b1;
                wr_addr = m_reg;
                wr_data = ival_reg;
            end
            ST_DDP_RDR:  rd_addr = i_reg;
            ST_DDP_RDK:  rd_addr = j_reg;
            ST_DDP_WRW: begin
                mem_we  = 1'b1;
                wr_addr = w_reg;
                wr_data = ival_reg;
            end
            ST_FIN_RDF:  rd_addr = C_ZERO;
            ST_FIN_RDB:  rd_addr = cnt_reg - C_ONE;
            default: begin
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

`ifndef SYNTH
    // count never passes the list depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= C_DEPTH) else $error("count above depth");

    // memory writes stay inside the array
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (wr_addr < C_DEPTH)) else $error("write out of range");

    // an empty result carries zero count, front and back
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[73]) |-> (m_tdata[72:2] == '0))
        else $error("empty flag mismatch");

    // a new word starts the sequencer
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word left sequencer idle");
`endif

endmodule

/* tb/tb_bounded_integer_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_bounded_integer_list_engine
// Self-checking bench for the bounded integer list engine: a queue-fed driver
// sends mode/value words with random gaps, a local list model predicts each
// result word, and a monitor with random stalls compares them field by field.
// ----------------------------------------------------------------------------
module tb_bounded_integer_list_engine;
    import bile_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } list_op_t;

    // packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic               empty;
        logic [6:0]         count;
        logic signed [31:0] back;
        logic signed [31:0] front;
        logic [1:0]         status;
    } list_view_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    bounded_integer_list_engine #(.DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow of the list contents
    logic signed [31:0] shadow_list[$];
    list_op_t           pending_ops[$];
    list_view_t         expected_views[$];
    int                 errors = 0;
    bit                 hold_off = 0;
    bit                 in_fire = 0;
    bit                 out_fire = 0;
    bit                 sent;
    bit                 taken;

    // apply one operation to the shadow list and return the resulting view
    function automatic list_view_t apply_list_op(list_op_t op);
        list_view_t         r;
        logic signed [31:0] kept[$];
        logic signed [31:0] t;
        int                 p;
        bit                 dup;
        r = '0;
        r.status = STATUS_DONE;
        case (op.mode)
            MODE_PUSH_FRONT: begin
                if (shadow_list.size() >= DEPTH) r.status = STATUS_FULL;
                else shadow_list.insert(0, op.value);
            end
            MODE_PUSH_BACK: begin
                if (shadow_list.size() >= DEPTH) r.status = STATUS_FULL;
                else shadow_list.insert(shadow_list.size(), op.value);
            end
            MODE_POP_FRONT: begin
                if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
                else shadow_list.delete(0);
            end
            MODE_INSERT: begin
                if (shadow_list.size() >= DEPTH) r.status = STATUS_FULL;
                else if (shadow_list.size() == 0 || op.value <= shadow_list[0])
                    shadow_list.insert(0, op.value);
                else if (op.value >= shadow_list[$])
                    shadow_list.insert(shadow_list.size(), op.value);
                else begin
                    p = 1;
                    while (p < shadow_list.size() && shadow_list[p] < op.value) p++;
                    shadow_list.insert(p, op.value);
                end
            end
            MODE_SORT: begin
                for (int i = 0; i + 1 < shadow_list.size(); i++)
                    for (int j = i + 1; j < shadow_list.size(); j++)
                        if (shadow_list[j] < shadow_list[i]) begin
                            t = shadow_list[i];
                            shadow_list[i] = shadow_list[j];
                            shadow_list[j] = t;
                        end
            end
            MODE_DEDUP: begin
                foreach (shadow_list[i]) begin
                    dup = 0;
                    foreach (kept[k]) if (kept[k] == shadow_list[i]) dup = 1;
                    if (!dup) kept = {kept, shadow_list[i]};
                end
                shadow_list = kept;
            end
            MODE_CLEAR: shadow_list.delete();
            default: ;
        endcase
        r.count = 7'(shadow_list.size());
        r.empty = (shadow_list.size() == 0);
        if (shadow_list.size() != 0) begin
            r.front = shadow_list[0];
            r.back  = shadow_list[$];
        end
        return r;
    endfunction

    // input accept: predict the result of each word taken
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            in_fire = 1'b1;
            expected_views = {expected_views, apply_list_op(pending_ops[0])};
            pending_ops.delete(0);
        end
    end

    // driver: one word at a time, random gap before each
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            sent    = in_fire;
            in_fire = 1'b0;
            if (sent)
                send_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            if (s_tvalid && !sent) begin
                // hold current word
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_ops[0].value, pending_ops[0].mode};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall: random per word, plus a long hold-off window
    int recv_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            taken    = out_fire;
            out_fire = 1'b0;
            if (taken)
                recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (aresetn && pending_ops.size() > 0 && pending_ops.size() < 600);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    // monitor
    list_view_t got, want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            out_fire = 1'b1;
            got = m_tdata[73:0];
            if (m_tdata[79:74] != 0 || expected_views.size() == 0) begin
                $display("%0t unexpected or malformed word: expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = expected_views[0];
                expected_views.delete(0);
                if (got.status != want.status) begin
                    $display("%0t status: expected %0d actual %0d", $time, want.status,
                             got.status);
                    errors++;
                end
                if (got.front != want.front) begin
                    $display("%0t front: expected %0d actual %0d", $time, want.front,
                             got.front);
                    errors++;
                end
                if (got.back != want.back) begin
                    $display("%0t back: expected %0d actual %0d", $time, want.back,
                             got.back);
                    errors++;
                end
                if (got.count != want.count) begin
                    $display("%0t count: expected %0d actual %0d", $time, want.count,
                             got.count);
                    errors++;
                end
                if (got.empty != want.empty) begin
                    $display("%0t empty: expected %0d actual %0d", $time, want.empty,
                             got.empty);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_value(int span);
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic queue_op(logic [2:0] m, logic signed [31:0] v);
        list_op_t op;
        op.mode  = m;
        op.value = v;
        pending_ops = {pending_ops, op};
    endtask

    // stimulus
    int         span;
    int         len;
    logic [2:0] rmode;
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-list cases, extremes, every operation
        queue_op(MODE_POP_FRONT, 0);
        queue_op(MODE_SORT, 0);
        queue_op(MODE_DEDUP, 0);
        queue_op(MODE_QUERY, 32'sh7fff_ffff);
        queue_op(MODE_INSERT, 5);
        queue_op(MODE_INSERT, 5);
        queue_op(MODE_INSERT, 32'sh8000_0000);
        queue_op(MODE_INSERT, 32'sh7fff_ffff);
        queue_op(MODE_INSERT, 3);
        queue_op(MODE_INSERT, 6);
        queue_op(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        queue_op(MODE_PUSH_BACK, 32'sh8000_0000);
        queue_op(MODE_PUSH_BACK, -1);
        queue_op(MODE_SORT, 0);
        queue_op(MODE_DEDUP, 0);
        queue_op(MODE_POP_FRONT, 0);
        queue_op(MODE_CLEAR, 0);
        queue_op(MODE_QUERY, 0);
        // fill to capacity, then refuse each adding mode
        for (int i = 0; i < DEPTH; i++) queue_op(MODE_PUSH_BACK, DEPTH - i);
        queue_op(MODE_PUSH_FRONT, 1);
        queue_op(MODE_PUSH_BACK, 1);
        queue_op(MODE_INSERT, 1);
        queue_op(MODE_SORT, 0);
        queue_op(MODE_CLEAR, 0);

        // random: runs that build the list up, reorder it, then clear it or pop from its front
        while (pending_ops.size() < 1100) begin
            span = $urandom_range(0, 1) ? 8 : 100000;
            len  = $urandom_range(1, 80);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) rmode = 3'($urandom_range(0, 7));
                else if ($urandom_range(0, 2) == 0) rmode = MODE_PUSH_FRONT;
                else if ($urandom_range(0, 1) == 1) rmode = MODE_INSERT;
                else rmode = MODE_PUSH_BACK;
                queue_op(rmode, pick_value(span));
            end
            queue_op($urandom_range(0, 1) ? MODE_SORT : MODE_DEDUP, 0);
            if ($urandom_range(0, 2) == 0) queue_op(MODE_CLEAR, 0);
            else for (int i = 0; i < 10; i++) queue_op(MODE_POP_FRONT, 0);
        end
        queue_op(MODE_QUERY, 0);

        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_views.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #250_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
